// ----- design/mt_pkg.sv -----
// Shared constants, types and the tempering function of the word generator.
package mt_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int POS_W        = $clog2(STATE_WORDS);

	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] SEED_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(STATE_WORDS - 1);

	// seeder -> chain: one seed word pushed into the tail per cycle
	typedef struct packed {
		logic        push;
		logic [31:0] word;
	} seed_stat_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ----- design/mt_cell.sv -----
// One state word of the twister shift chain.
module mt_cell
	import mt_pkg::*;
(
	input  logic        clk,
	input  logic        shift,
	input  logic [31:0] d,
	output logic [31:0] q
);

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ----- design/mt_seeder.sv -----
// Seeding recurrence: produces one initial state word per cycle into the chain tail.
module mt_seeder
	import mt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] seed,
	output seed_stat_t  stat
);

	logic             active_q;
	logic [POS_W-1:0] count_q;
	logic [31:0]      prev_q;
	logic [31:0]      mixed;
	logic [31:0]      next_word;

	assign mixed     = prev_q ^ (prev_q >> 30);
	assign next_word = (count_q == '0) ? seed
	                 : 32'(SEED_MULT * mixed) + {{(32-POS_W){1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			count_q  <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			count_q  <= '0;
		end else if (active_q) begin
			if (count_q == LAST_POS) begin
				active_q <= 1'b0;
			end
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q && !start) begin
			prev_q <= next_word;
		end
	end

	assign stat.push = active_q;
	assign stat.word = next_word;

endmodule

// ----- design/mt_out_buf.sv -----
// Output register with a skid stage so input stays open while a result waits.
module mt_out_buf
	import mt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] in_data,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_data
);

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        skid_valid_q;
	logic [31:0] skid_data_q;
	logic        open;

	assign open     = !out_valid_q || out_ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (open) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (open) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_valid) begin
				out_data_q <= in_data;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- design/mersenne_twister_word_generator.sv -----
// Top level of the MT19937 word generator: state chain, twist, tempering, output buffer.
//
// Usage:
//   s_axis: one item per request; tdata[0] = narrow_mode (1 gives the word >> 1).
//   m_axis: one item per request; tdata[31:0] = random_word, in request order.
//   cfg:    write the 32-bit seed; the state is refilled and the sequence restarts.
// The 624-word state sits in a row of cells that shifts by one word per item:
// cell 0 is the word being replaced, cells 1 and 397 are the other two taps and
// the fresh word enters at the tail, so positions never need addressing.
// A result is registered in the output buffer, or in its skid register, before m_axis.
// Throughput: one item per cycle outside fills and m_axis stalls (combinational twist).
// Reset and every seed write start a fill of the 624 state words (one multiply-add per
// cycle in the seeder); s_axis_tready stays low during the fill. Reset loads
// seed 5489. cfg_ready is always high.
// When m_axis stalls, one more item is held in a skid register; s_axis_tready
// drops only once both output and skid are full.
module mersenne_twister_word_generator
	import mt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write channel: seed_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// request items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] narrow_mode, [7:1] zero
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] random_word
);

	logic [31:0] seed_q;
	logic        cfg_wr;
	seed_stat_t  seed_stat;

	logic [31:0] chain_w [STATE_WORDS];
	logic        shift;
	logic [31:0] tail_in;

	logic        accept;
	logic        buf_ready;
	logic [31:0] joined;
	logic [31:0] fresh;
	logic [31:0] tempered;
	logic [31:0] result;

	// seed register
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= DEFAULT_SEED;
		end else if (cfg_wr) begin
			seed_q <= cfg_data;
		end
	end

	mt_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.seed   (seed_q),
		.stat   (seed_stat)
	);

	// twist: taps at fixed cells of the chain
	assign joined = {chain_w[0][31], chain_w[1][30:0]};
	assign fresh  = chain_w[TWIST_OFFSET] ^ (joined >> 1) ^ (joined[0] ? TWIST_MATRIX : '0);

	assign s_axis_tready = !seed_stat.push && buf_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// chain advances on each pushed seed word or accepted item
	assign shift   = seed_stat.push || accept;
	assign tail_in = seed_stat.push ? seed_stat.word : fresh;

	for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
		if (k == STATE_WORDS - 1) begin : g_tail
			mt_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (tail_in),
				.q     (chain_w[k])
			);
		end else begin : g_body
			mt_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (chain_w[k+1]),
				.q     (chain_w[k])
			);
		end
	end

	assign tempered = temper(fresh);
	assign result   = s_axis_tdata[0] ? {1'b0, tempered[31:1]} : tempered;

	mt_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_data   (result),
		.in_ready  (buf_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ----- tb/sv/tb_mersenne_twister_word_generator.sv -----
// Self-checking bench of the MT19937 word generator: seeded request table, then random phases.
`timescale 1ns / 100ps

module tb_mersenne_twister_word_generator;
	import mt_pkg::*;

	localparam int ITEMS_PER_PHASE = 338;
	localparam int NUM_PHASES      = 4;
	localparam int HOLD_CYCLES     = 200;
	// covers the quiet spells of a seed fill and of the long output hold
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int TAIL_CYCLES     = 10;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic {ROW_ITEM, ROW_SEED} plan_kind_e;

	// value is the seed for ROW_SEED, the literal expected word where has_literal is set
	typedef struct {
		plan_kind_e  kind;
		logic        narrow;
		logic        has_literal;
		logic [31:0] value;
	} plan_row_t;

	localparam int PLAN_ROWS = 18;

	plan_row_t seeded_plan [PLAN_ROWS] = '{
		// default seed after reset: first words of the standard sequence
		'{ROW_ITEM, 1'b0, 1'b1, 32'd3499211612},
		'{ROW_ITEM, 1'b0, 1'b1, 32'd581869302},
		'{ROW_ITEM, 1'b1, 1'b1, 32'd1945173367},
		'{ROW_ITEM, 1'b0, 1'b1, 32'd3586334585},
		'{ROW_ITEM, 1'b1, 1'b1, 32'd272702102},
		// seed extremes
		'{ROW_SEED, 1'b0, 1'b0, 32'h0000_0000},
		'{ROW_ITEM, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, 1'b0, 1'b0, 32'd0},
		'{ROW_SEED, 1'b0, 1'b0, 32'hffff_ffff},
		'{ROW_ITEM, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, 1'b0, 1'b0, 32'd0},
		// reseed mid-sequence back to the default: sequence restarts; then seed 8000_0000
		'{ROW_SEED, 1'b0, 1'b0, DEFAULT_SEED},
		'{ROW_ITEM, 1'b0, 1'b1, 32'd3499211612},
		'{ROW_ITEM, 1'b1, 1'b1, 32'd290934651},
		'{ROW_SEED, 1'b0, 1'b0, 32'h8000_0000},
		'{ROW_ITEM, 1'b1, 1'b0, 32'd0}
	};

	int send_idle_pct  [NUM_PHASES] = '{0, 75, 0, 36};
	int recv_stall_pct [NUM_PHASES] = '{0, 0, 75, 36};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [0] narrow_mode, [7:1] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [31:0] random_word

	// predictor state
	logic [31:0] twist_state [STATE_WORDS];
	int unsigned twist_pos;
	logic [31:0] pending_words [$];

	int idle_pct;
	int stall_pct;
	int word_errors;
	int hold_ask;
	int hold_done;
	int hold_left;

	mersenne_twister_word_generator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] temper_word(input logic [31:0] w);
		logic [31:0] t;
		t = w ^ {11'd0, w[31:11]};
		t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
		t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
		return t ^ {18'd0, t[31:18]};
	endfunction

	function automatic void fill_model(input logic [31:0] seed);
		twist_state[0] = seed;
		for (int i = 1; i < STATE_WORDS; i++) begin
			twist_state[i] = SEED_MULT * (twist_state[i-1] ^ (twist_state[i-1] >> 30))
				+ 32'(i);
		end
		twist_pos = 0;
	endfunction

	// regenerate the word at the current position, temper it, advance
	function automatic logic [31:0] next_random_word(input logic narrow);
		int unsigned nxt;
		int unsigned far;
		logic [31:0] joined;
		logic [31:0] fresh;
		logic [31:0] word;
		nxt    = (twist_pos + 1) % STATE_WORDS;
		far    = (twist_pos + TWIST_OFFSET) % STATE_WORDS;
		joined = {twist_state[twist_pos][31], twist_state[nxt][30:0]};
		fresh  = twist_state[far] ^ {1'b0, joined[31:1]};
		if (joined[0])
			fresh = fresh ^ TWIST_MATRIX;
		twist_state[twist_pos] = fresh;
		twist_pos = nxt;
		word = temper_word(fresh);
		return narrow ? {1'b0, word[31:1]} : word;
	endfunction

	task automatic report_error(input string msg);
		word_errors++;
		if (word_errors <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endtask

	task automatic offer_request(input logic narrow, input logic has_literal,
			input logic [31:0] literal);
		logic [31:0] predicted;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, narrow};
		do @(posedge clk); while (!s_axis_tready);
		predicted = next_random_word(narrow);
		pending_words.push_back(has_literal ? literal : predicted);
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// only with nothing in flight; the block refills its state afterwards
	task automatic write_seed(input logic [31:0] seed);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fill_model(seed);
	endtask

	// result side: check against the oldest expectation, random stalls, long hold on request
	always @(posedge clk) begin
		logic [31:0] want;
		if (hold_ask != hold_done) begin
			hold_done = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				report_error($sformatf("unexpected random_word %h", m_axis_tdata));
			end else begin
				want = pending_words.pop_front();
				if (m_axis_tdata !== want)
					report_error($sformatf("random_word expected %h got %h",
						want, m_axis_tdata));
			end
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles with no handshake anywhere
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		word_errors = 0;
		hold_ask    = 0;
		hold_done   = 0;
		hold_left   = 0;
		idle_pct    = 0;
		stall_pct   = 0;
		fill_model(DEFAULT_SEED);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (seeded_plan[r]) begin
			if (seeded_plan[r].kind == ROW_SEED)
				write_seed(seeded_plan[r].value);
			else
				offer_request(seeded_plan[r].narrow, seeded_plan[r].has_literal,
					seeded_plan[r].value);
		end

		// reseed only every other phase so the position wraps within each pair
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			idle_pct  = send_idle_pct[ph];
			stall_pct = recv_stall_pct[ph];
			if (ph % 2 == 0)
				write_seed($urandom);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 100)
					hold_ask <= hold_ask + 1;
				if (ph == 0 && n == 250)
					drain_results();
				offer_request(1'($urandom_range(1)), 1'b0, 32'd0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (word_errors == 0 && pending_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
